// ===== hdl/mhe_pkg.sv =====
package mhe_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int KEY_W     = 32;
    localparam int TAG_W     = 16;
    localparam int POS_W     = 8;
    localparam int COUNT_W   = 9;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_POP   = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ONE,
        ST_B_LDV,
        ST_B_CMP,
        ST_B_PUT,
        ST_P_RD0,
        ST_P_RDL,
        ST_P_LDV,
        ST_P_RDC1,
        ST_P_RDC2,
        ST_P_CMP,
        ST_P_FIN,
        ST_P_TAIL
    } state_t;

endpackage

// ===== hdl/min_heap_extract_to_tail_top.sv =====
// Min-heap pop engine over a (key, tag) store.
// Command channel: a word is taken at a rising edge with start high and busy low.
// cmd write stores key and tag at position; busy stays low and no
// result follows. A write at or beyond DEPTH is dropped.
// cmd pop takes count (saturated to DEPTH) and heap_ready. A result word is shown
// on min_key, min_tag and empty_res for one cycle with done high; it cannot be
// held off by the receiver.
// Pop sequence, set by the single-port store read and the shared key comparator:
//   count 0: done in the cycle after the pop, busy stays low.
//   count 1: the root entry is read and shown as the result.
//   heap ready: root and tail reads, then per sift level, up to log2(count) levels
//   (left child read, right child read and compare, compare against the moved entry).
//   heap build first: each of entries 1..count-1 is first sifted up toward the root.
// One pop is in flight at a time; busy drops in the cycle its result word is shown.
// Reset clears the sequencer and the done strobe; the store contents are not
// cleared and must be written before use.
module min_heap_extract_to_tail_top #(
    parameter int DEPTH = mhe_pkg::DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           cmd,
    input  logic [mhe_pkg::POS_W-1:0]      position,
    input  logic signed [mhe_pkg::KEY_W-1:0] key,
    input  logic [mhe_pkg::TAG_W-1:0]      tag,
    input  logic [mhe_pkg::COUNT_W-1:0]    count,
    input  logic                           heap_ready,
    output logic                           done,
    output logic signed [mhe_pkg::KEY_W-1:0] min_key,
    output logic [mhe_pkg::TAG_W-1:0]      min_tag,
    output logic                           empty_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    mhe_pkg::entry_t mem [DEPTH];

    mhe_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   last_reg, last_next;
    logic [AW-1:0]   k_reg, k_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic [CW-1:0]   c_reg, c_next;
    logic [AW-1:0]   bc_reg, bc_next;
    mhe_pkg::entry_t v_reg, v_next;
    mhe_pkg::entry_t top_reg, top_next;
    mhe_pkg::entry_t best_reg, best_next;
    mhe_pkg::entry_t rd_data_reg;
    logic            done_reg, done_next;
    logic            empty_reg, empty_next;
    logic [mhe_pkg::KEY_W-1:0] min_key_reg, min_key_next;
    logic [mhe_pkg::TAG_W-1:0] min_tag_reg, min_tag_next;

    logic            we;
    logic [AW-1:0]   wa;
    mhe_pkg::entry_t wd;
    logic            re;
    logic [AW-1:0]   ra;

    logic [mhe_pkg::KEY_W-1:0] cmp_a, cmp_b;
    logic            lt;
    logic [CW-1:0]   n_sat;
    logic [AW-1:0]   par;
    logic [CW-1:0]   c_inc;
    logic [CW-1:0]   c_child;

    // shared key comparator
    always_comb
    begin
        case (state_reg)
            mhe_pkg::ST_B_CMP:
            begin
                cmp_a = v_reg.key;
                cmp_b = rd_data_reg.key;
            end
            mhe_pkg::ST_P_RDC2:
            begin
                cmp_a = rd_data_reg.key;
                cmp_b = best_reg.key;
            end
            mhe_pkg::ST_P_CMP:
            begin
                cmp_a = best_reg.key;
                cmp_b = v_reg.key;
            end
            default:
            begin
                cmp_a = rd_data_reg.key;
                cmp_b = v_reg.key;
            end
        endcase
    end

    assign lt = $signed(cmp_a) < $signed(cmp_b);

    assign n_sat   = (int'(count) > DEPTH) ? CW'(DEPTH) : CW'(count);
    assign par     = (pos_reg - AW'(1)) >> 1;
    assign c_inc   = c_reg + CW'(1);
    assign c_child = {bc_reg, 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mhe_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg    <= last_next;
        k_reg       <= k_next;
        pos_reg     <= pos_next;
        c_reg       <= c_next;
        bc_reg      <= bc_next;
        v_reg       <= v_next;
        top_reg     <= top_next;
        best_reg    <= best_next;
        empty_reg   <= empty_next;
        min_key_reg <= min_key_next;
        min_tag_reg <= min_tag_next;
    end

    // entry store
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_data_reg <= mem[ra];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        last_next    = last_reg;
        k_next       = k_reg;
        pos_next     = pos_reg;
        c_next       = c_reg;
        bc_next      = bc_reg;
        v_next       = v_reg;
        top_next     = top_reg;
        best_next    = best_reg;
        done_next    = 1'b0;
        empty_next   = empty_reg;
        min_key_next = min_key_reg;
        min_tag_next = min_tag_reg;
        we           = 1'b0;
        wa           = '0;
        wd           = '0;
        re           = 1'b0;
        ra           = '0;

        case (state_reg)
            mhe_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd == mhe_pkg::CMD_WRITE)
                    begin
                        if (int'(position) < DEPTH)
                        begin
                            we     = 1'b1;
                            wa     = AW'(position);
                            wd.key = key;
                            wd.tag = tag;
                        end
                    end
                    else if (n_sat == '0)
                    begin
                        done_next    = 1'b1;
                        empty_next   = 1'b1;
                        min_key_next = '0;
                        min_tag_next = '0;
                    end
                    else
                    begin
                        last_next  = n_sat - CW'(1);
                        empty_next = 1'b0;
                        re         = 1'b1;
                        if (n_sat == CW'(1))
                        begin
                            ra         = '0;
                            state_next = mhe_pkg::ST_ONE;
                        end
                        else if (heap_ready)
                        begin
                            ra         = '0;
                            state_next = mhe_pkg::ST_P_RDL;
                        end
                        else
                        begin
                            ra         = AW'(1);
                            k_next     = AW'(1);
                            pos_next   = AW'(1);
                            state_next = mhe_pkg::ST_B_LDV;
                        end
                    end
                end
            end

            mhe_pkg::ST_ONE:
            begin
                done_next    = 1'b1;
                min_key_next = rd_data_reg.key;
                min_tag_next = rd_data_reg.tag;
                state_next   = mhe_pkg::ST_IDLE;
            end

            // build: sift entry k up toward the root
            mhe_pkg::ST_B_LDV:
            begin
                v_next     = rd_data_reg;
                re         = 1'b1;
                ra         = par;
                state_next = mhe_pkg::ST_B_CMP;
            end

            mhe_pkg::ST_B_CMP:
            begin
                we = 1'b1;
                wa = pos_reg;
                if (lt)
                begin
                    wd       = rd_data_reg;
                    pos_next = par;
                    if (par == '0)
                    begin
                        state_next = mhe_pkg::ST_B_PUT;
                    end
                    else
                    begin
                        re = 1'b1;
                        ra = (par - AW'(1)) >> 1;
                    end
                end
                else
                begin
                    wd = v_reg;
                    if ({1'b0, k_reg} < last_reg)
                    begin
                        k_next     = k_reg + AW'(1);
                        pos_next   = k_reg + AW'(1);
                        re         = 1'b1;
                        ra         = k_reg + AW'(1);
                        state_next = mhe_pkg::ST_B_LDV;
                    end
                    else
                    begin
                        state_next = mhe_pkg::ST_P_RD0;
                    end
                end
            end

            mhe_pkg::ST_B_PUT:
            begin
                we = 1'b1;
                wa = pos_reg;
                wd = v_reg;
                if ({1'b0, k_reg} < last_reg)
                begin
                    k_next     = k_reg + AW'(1);
                    pos_next   = k_reg + AW'(1);
                    re         = 1'b1;
                    ra         = k_reg + AW'(1);
                    state_next = mhe_pkg::ST_B_LDV;
                end
                else
                begin
                    state_next = mhe_pkg::ST_P_RD0;
                end
            end

            // pop: root to tail, last entry sifts down
            mhe_pkg::ST_P_RD0:
            begin
                re         = 1'b1;
                ra         = '0;
                state_next = mhe_pkg::ST_P_RDL;
            end

            mhe_pkg::ST_P_RDL:
            begin
                top_next   = rd_data_reg;
                re         = 1'b1;
                ra         = last_reg[AW-1:0];
                state_next = mhe_pkg::ST_P_LDV;
            end

            mhe_pkg::ST_P_LDV:
            begin
                v_next   = rd_data_reg;
                pos_next = '0;
                c_next   = CW'(1);
                if (last_reg <= CW'(1))
                begin
                    state_next = mhe_pkg::ST_P_FIN;
                end
                else
                begin
                    re         = 1'b1;
                    ra         = AW'(1);
                    state_next = mhe_pkg::ST_P_RDC1;
                end
            end

            mhe_pkg::ST_P_RDC1:
            begin
                best_next = rd_data_reg;
                bc_next   = c_reg[AW-1:0];
                if (c_inc < last_reg)
                begin
                    re         = 1'b1;
                    ra         = c_inc[AW-1:0];
                    state_next = mhe_pkg::ST_P_RDC2;
                end
                else
                begin
                    state_next = mhe_pkg::ST_P_CMP;
                end
            end

            mhe_pkg::ST_P_RDC2:
            begin
                if (lt)
                begin
                    best_next = rd_data_reg;
                    bc_next   = c_inc[AW-1:0];
                end
                state_next = mhe_pkg::ST_P_CMP;
            end

            mhe_pkg::ST_P_CMP:
            begin
                if (lt)
                begin
                    we       = 1'b1;
                    wa       = pos_reg;
                    wd       = best_reg;
                    pos_next = bc_reg;
                    c_next   = c_child;
                    if (c_child >= last_reg)
                    begin
                        state_next = mhe_pkg::ST_P_FIN;
                    end
                    else
                    begin
                        re         = 1'b1;
                        ra         = c_child[AW-1:0];
                        state_next = mhe_pkg::ST_P_RDC1;
                    end
                end
                else
                begin
                    state_next = mhe_pkg::ST_P_FIN;
                end
            end

            mhe_pkg::ST_P_FIN:
            begin
                we         = 1'b1;
                wa         = pos_reg;
                wd         = v_reg;
                state_next = mhe_pkg::ST_P_TAIL;
            end

            mhe_pkg::ST_P_TAIL:
            begin
                we           = 1'b1;
                wa           = last_reg[AW-1:0];
                wd           = top_reg;
                done_next    = 1'b1;
                min_key_next = top_reg.key;
                min_tag_next = top_reg.tag;
                state_next   = mhe_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = mhe_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != mhe_pkg::ST_IDLE);
    assign done      = done_reg;
    assign empty_res = empty_reg;
    assign min_key   = min_key_reg;
    assign min_tag   = min_tag_reg;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && empty_res) |-> (min_key == '0 && min_tag == '0))
        else $error("empty result word carries nonzero fields");

    a_pop_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == mhe_pkg::CMD_POP) |=> (busy || done))
        else $error("pop accepted without work or result");

    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == mhe_pkg::CMD_WRITE) |=> (!busy && !done))
        else $error("write produced a result or busy");

    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("pop finished without a result word");
`endif

endmodule

// ===== tb/sv/tb_min_heap_extract_to_tail_top.sv =====
module tb_min_heap_extract_to_tail_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_DEPTH = mhe_pkg::DEPTH_DEF;
    localparam int KEY_W      = mhe_pkg::KEY_W;
    localparam int TAG_W      = mhe_pkg::TAG_W;
    localparam int POS_W      = mhe_pkg::POS_W;
    localparam int COUNT_W    = mhe_pkg::COUNT_W;
    localparam int WORD_GOAL  = 1450;
    localparam int CALM_TAIL  = 120;

    typedef struct {
        logic               cmd;
        logic [POS_W-1:0]   position;
        logic [KEY_W-1:0]   key;
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] count;
        logic               heap_ready;
        bit                 wait_drain;
    } cmd_word_t;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             empty;
    } min_word_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      cmd;
    logic [POS_W-1:0]          position;
    logic signed [KEY_W-1:0]   key;
    logic [TAG_W-1:0]          tag;
    logic [COUNT_W-1:0]        count;
    logic                      heap_ready;
    logic                      done;
    logic signed [KEY_W-1:0]   min_key;
    logic [TAG_W-1:0]          min_tag;
    logic                      empty_res;

    logic signed [KEY_W-1:0]   shadow_keys [HEAP_DEPTH];
    logic [TAG_W-1:0]          shadow_tags [HEAP_DEPTH];

    cmd_word_t  pending_words[$];
    min_word_t  expected_mins[$];
    cmd_word_t  next_word;
    min_word_t  oldest_min;
    bit         word_taken;
    int         idle_left;
    int         planned;
    int         errors;

    min_heap_extract_to_tail_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .position   (position),
        .key        (key),
        .tag        (tag),
        .count      (count),
        .heap_ready (heap_ready),
        .done       (done),
        .min_key    (min_key),
        .min_tag    (min_tag),
        .empty_res  (empty_res)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (errors < 40)
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // sift-up insertion of entries 1..n-1, strict less-than
    task automatic build_by_insertion(input int n);
        int pos;
        int up;
        bit moving;
        logic signed [KEY_W-1:0] v;
        logic [TAG_W-1:0] g;
        for (int k = 1; k < n; k++)
        begin
            pos = k;
            v = shadow_keys[k];
            g = shadow_tags[k];
            moving = 1'b1;
            while (pos > 0 && moving)
            begin
                up = (pos - 1) / 2;
                if (v < shadow_keys[up])
                begin
                    shadow_keys[pos] = shadow_keys[up];
                    shadow_tags[pos] = shadow_tags[up];
                    pos = up;
                end
                else
                    moving = 1'b0;
            end
            shadow_keys[pos] = v;
            shadow_tags[pos] = g;
        end
    endtask

    // root goes to n-1, old tail sifts down over 0..n-2
    task automatic move_min_to_tail(input int n, output min_word_t r);
        int last;
        int pos;
        int c;
        bit moving;
        logic signed [KEY_W-1:0] top_k;
        logic signed [KEY_W-1:0] v;
        logic [TAG_W-1:0] top_g;
        logic [TAG_W-1:0] g;
        top_k = shadow_keys[0];
        top_g = shadow_tags[0];
        v = shadow_keys[n-1];
        g = shadow_tags[n-1];
        last = n - 1;
        pos = 0;
        moving = 1'b1;
        while (moving)
        begin
            c = 2 * pos + 1;
            if (c >= last)
                moving = 1'b0;
            else
            begin
                if (c + 1 < last && shadow_keys[c+1] < shadow_keys[c])
                    c++;
                if (shadow_keys[c] < v)
                begin
                    shadow_keys[pos] = shadow_keys[c];
                    shadow_tags[pos] = shadow_tags[c];
                    pos = c;
                end
                else
                    moving = 1'b0;
            end
        end
        shadow_keys[pos] = v;
        shadow_tags[pos] = g;
        shadow_keys[last] = top_k;
        shadow_tags[last] = top_g;
        r.key = top_k;
        r.tag = top_g;
        r.empty = 1'b0;
    endtask

    task automatic apply_word(input logic w_cmd, input logic [POS_W-1:0] w_pos,
                              input logic [KEY_W-1:0] w_key, input logic [TAG_W-1:0] w_tag,
                              input logic [COUNT_W-1:0] w_count, input logic w_ready);
        int n;
        min_word_t r;
        if (w_cmd == mhe_pkg::CMD_WRITE)
        begin
            if (int'(w_pos) < HEAP_DEPTH)
            begin
                shadow_keys[w_pos] = w_key;
                shadow_tags[w_pos] = w_tag;
            end
        end
        else
        begin
            n = (int'(w_count) > HEAP_DEPTH) ? HEAP_DEPTH : int'(w_count);
            if (n == 0)
            begin
                r.key = '0;
                r.tag = '0;
                r.empty = 1'b1;
            end
            else if (n == 1)
            begin
                r.key = shadow_keys[0];
                r.tag = shadow_tags[0];
                r.empty = 1'b0;
            end
            else
            begin
                if (!w_ready)
                    build_by_insertion(n);
                move_min_to_tail(n, r);
            end
            expected_mins.push_back(r);
        end
    endtask

    function automatic logic [KEY_W-1:0] pick_key(input bit narrow);
        if (narrow)
            return KEY_W'($signed($urandom_range(0, 7)) - 4);
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_write(input int p, input logic [KEY_W-1:0] k,
                              input logic [TAG_W-1:0] t, input bit drain);
        cmd_word_t w;
        w.cmd = mhe_pkg::CMD_WRITE;
        w.position = POS_W'(p);
        w.key = k;
        w.tag = t;
        w.count = COUNT_W'($urandom);
        w.heap_ready = 1'($urandom);
        w.wait_drain = drain;
        pending_words.push_back(w);
        planned++;
    endtask

    task automatic push_pop(input int n, input logic rdy, input bit drain);
        cmd_word_t w;
        w.cmd = mhe_pkg::CMD_POP;
        w.position = POS_W'($urandom);
        w.key = $urandom;
        w.tag = TAG_W'($urandom);
        w.count = COUNT_W'(n);
        w.heap_ready = rdy;
        w.wait_drain = drain;
        pending_words.push_back(w);
        planned++;
    endtask

    // well-formed run: load, build, then pops on the shrinking heap
    task automatic push_heap_run(input bit drain);
        int k;
        int pops;
        bit narrow;
        k = ($urandom_range(0, 39) == 0) ? $urandom_range(100, HEAP_DEPTH)
                                           : $urandom_range(2, 20);
        narrow = ($urandom_range(0, 3) == 0);
        for (int p = 0; p < k; p++)
            push_write(p, pick_key(narrow), TAG_W'($urandom), drain && p == 0);
        push_pop(k, 1'b0, 1'b0);
        pops = $urandom_range(1, (k > 24) ? 24 : k - 1);
        for (int i = 1; i <= pops; i++)
            push_pop(k - i, 1'b1, 1'b0);
    endtask

    task automatic push_noise();
        int n;
        if ($urandom_range(0, 2) == 0)
            push_write($urandom_range(0, HEAP_DEPTH - 1), pick_key(1'b0),
                       TAG_W'($urandom), 1'b0);
        else
        begin
            n = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 24);
            push_pop(n, 1'($urandom), 1'b0);
        end
    endtask

    // word acceptance and prediction
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            word_taken = 1'b1;
            apply_word(cmd, position, key, tag, count, heap_ready);
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!(start && !word_taken))
        begin
            word_taken = 1'b0;
            if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
            end
            else if (pending_words.size() == 0
                     || (pending_words[0].wait_drain && expected_mins.size() != 0))
                start <= 1'b0;
            else
            begin
                next_word = pending_words.pop_front();
                cmd        <= next_word.cmd;
                position   <= next_word.position;
                key        <= next_word.key;
                tag        <= next_word.tag;
                count      <= next_word.count;
                heap_ready <= next_word.heap_ready;
                start      <= 1'b1;
                if (pending_words.size() > CALM_TAIL && $urandom_range(0, 4) == 0)
                    idle_left = $urandom_range(1, 5);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_mins.size() == 0)
                flag_mismatch("result word with no pop waiting", min_key, '0);
            else
            begin
                oldest_min = expected_mins.pop_front();
                if (min_key !== oldest_min.key)
                    flag_mismatch("min_key", min_key, oldest_min.key);
                if (min_tag !== oldest_min.tag)
                    flag_mismatch("min_tag", min_tag, oldest_min.tag);
                if (empty_res !== oldest_min.empty)
                    flag_mismatch("empty_res", empty_res, oldest_min.empty);
            end
        end
    end

    initial
    begin
        #200_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = mhe_pkg::CMD_WRITE;
        position = '0;
        key = '0;
        tag = '0;
        count = '0;
        heap_ready = 1'b0;
        word_taken = 1'b0;
        idle_left = 0;
        planned = 0;
        errors = 0;

        // every slot written before any pop reads it
        for (int p = 0; p < HEAP_DEPTH; p++)
            push_write(p, pick_key(1'b0), TAG_W'($urandom), 1'b0);

        // directed
        push_pop(0, 1'b0, 1'b0);
        push_pop(0, 1'b1, 1'b0);
        push_write(0, 32'h7fff_ffff, 16'hffff, 1'b0);
        push_pop(1, 1'b0, 1'b0);
        push_pop(1, 1'b1, 1'b0);
        push_write(0, 32'h7fff_ffff, 16'hffff, 1'b0);
        push_write(1, 32'h8000_0000, 16'h0000, 1'b0);
        push_write(2, 32'h0000_0000, 16'h5a5a, 1'b0);
        push_write(3, 32'hffff_ffff, 16'ha5a5, 1'b0);
        push_pop(4, 1'b0, 1'b0);
        push_pop(3, 1'b1, 1'b0);
        push_pop(2, 1'b1, 1'b0);
        // equal keys keep their place
        push_write(0, 32'h0001_0000, 16'h0001, 1'b0);
        push_write(1, 32'h0001_0000, 16'h0002, 1'b0);
        push_write(2, 32'h0001_0000, 16'h0003, 1'b0);
        push_pop(3, 1'b0, 1'b0);
        push_pop(2, 1'b1, 1'b0);
        // count beyond the store saturates
        push_write(255, 32'h8000_0000, 16'hbeef, 1'b0);
        push_pop(300, 1'b0, 1'b0);
        push_pop(511, 1'b1, 1'b0);
        push_pop(256, 1'b1, 1'b1);

        push_heap_run(1'b1);
        while (planned < WORD_GOAL)
        begin
            if ($urandom_range(0, 3) != 0)
                push_heap_run($urandom_range(0, 7) == 0);
            else
                push_noise();
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_words.size() != 0 || start)
            @(posedge clk);
        while (expected_mins.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/mhe_pkg.sv
hdl/min_heap_extract_to_tail_top.sv
tb/sv/tb_min_heap_extract_to_tail_top.sv
